// ===== design/sorted_key_value_override_table_unit_defines.svh =====
// Assertion macros for the override table unit.
`ifndef SORTED_KEY_VALUE_OVERRIDE_TABLE_UNIT_DEFINES_SVH
`define SORTED_KEY_VALUE_OVERRIDE_TABLE_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define SKVOT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("override table check failed");

// Next-cycle implication, disabled while reset is low.
`define SKVOT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("override table check failed");

`endif

// ===== design/skvot_pkg.sv =====
// ----------------------------------------------------------------------------
// skvot_pkg
// Types and constants for the sorted key/value override table.
// ----------------------------------------------------------------------------
package skvot_pkg;

    localparam int KEY_W = 16;
    localparam int VAL_W = 32;
    localparam int REQ_W = 2;

    localparam logic [KEY_W-1:0] EMPTY_KEY = {KEY_W{1'b1}};

    typedef enum logic [REQ_W-1:0] {
        REQ_STORE  = 2'd0,
        REQ_LOOKUP = 2'd1,
        REQ_REMOVE = 2'd2
    } t_req;

    // Broadcast control for every cell of the row
    typedef struct packed {
        logic             capture;
        logic             write_hit;
        logic             insert;
        logic             remove;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } t_cell_ctl;

endpackage

// ===== design/sorted_key_value_override_table_unit.sv =====
// ----------------------------------------------------------------------------
// sorted_key_value_override_table_unit
// Sorted key/value table in a row of cells with store, lookup and remove.
// ----------------------------------------------------------------------------
// busy is high for the compare cycle after the accepting edge, in which
//   every cell registers its less-than and equal flags. The apply cycle then
//   reduces the flags, shifts the row in one step and registers the result
//   strobe; a new request can already be accepted during the apply cycle.
// Reset: synchronous, active low; all slots hold the empty mark, count zero.
// The receiver cannot stall: o_valid is high for one cycle per request.
`include "sorted_key_value_override_table_unit_defines.svh"

module sorted_key_value_override_table_unit #(
    parameter int CAPACITY = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [skvot_pkg::REQ_W-1:0]  i_req_type,
    input  logic [skvot_pkg::KEY_W-1:0]  i_param_key,
    input  logic [skvot_pkg::VAL_W-1:0]  i_new_value,
    output logic                         o_valid,
    output logic                         o_done_ok,
    output logic                         o_hit,
    output logic [skvot_pkg::VAL_W-1:0]  o_read_value,
    output logic [$clog2(CAPACITY+1)-1:0] o_entry_count
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic                        r_busy;
    logic                        r_apply;
    logic [skvot_pkg::REQ_W-1:0] r_req;
    logic [skvot_pkg::KEY_W-1:0] r_key;
    logic [skvot_pkg::VAL_W-1:0] r_val;
    logic [CNT_W-1:0]            r_count;
    logic [CNT_W-1:0]            n_count;

    logic                        accept;
    logic                        op_ok;
    logic                        present;
    logic                        full;
    logic [skvot_pkg::VAL_W-1:0] hit_value;
    skvot_pkg::t_cell_ctl        ctl;

    logic [skvot_pkg::KEY_W-1:0] cell_key   [CAPACITY];
    logic [skvot_pkg::VAL_W-1:0] cell_value [CAPACITY];
    logic [CAPACITY-1:0]         cell_lt;
    logic [CAPACITY-1:0]         cell_eq;

    assign accept = start && !busy;
    assign busy   = r_busy;

    // Latch the request beat
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req <= i_req_type;
            r_key <= i_param_key;
            r_val <= i_new_value;
        end
    end

    // Sequence compare and apply cycles
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_apply <= 1'b0;
        end else begin
            r_busy  <= accept;
            r_apply <= r_busy;
        end
    end

    // Reduce the cell flags
    always_comb begin
        hit_value = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            hit_value = hit_value | (cell_value[i] & {skvot_pkg::VAL_W{cell_eq[i]}});
        end
    end

    assign present = |cell_eq;
    assign full    = (r_count == CNT_W'(CAPACITY));
    assign op_ok   = (r_key != skvot_pkg::EMPTY_KEY) &&
                     ((r_req == skvot_pkg::REQ_STORE) ||
                      (r_req == skvot_pkg::REQ_LOOKUP) ||
                      (r_req == skvot_pkg::REQ_REMOVE));

    // Drive the row control
    always_comb begin
        ctl.capture   = r_busy;
        ctl.key       = r_key;
        ctl.value     = r_val;
        ctl.write_hit = r_apply && op_ok && (r_req == skvot_pkg::REQ_STORE) && present;
        ctl.insert    = r_apply && op_ok && (r_req == skvot_pkg::REQ_STORE) && !present
                        && !full;
        ctl.remove    = r_apply && op_ok && (r_req == skvot_pkg::REQ_REMOVE) && present;
    end

    // Advance the entry count
    always_comb begin
        n_count = r_count;
        if (ctl.insert) begin
            n_count = r_count + CNT_W'(1);
        end else if (ctl.remove) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // Register the result beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_apply;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_apply) begin
            o_done_ok     <= ctl.write_hit || ctl.insert || ctl.remove;
            o_hit         <= op_ok && present;
            o_read_value  <= (op_ok && (r_req == skvot_pkg::REQ_LOOKUP) && present) ?
                             hit_value : '0;
            o_entry_count <= n_count;
        end
    end

    // Row of cells, each linked to its neighbours
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [skvot_pkg::KEY_W-1:0] below_key;
        logic [skvot_pkg::VAL_W-1:0] below_value;
        logic                        below_lt;
        logic [skvot_pkg::KEY_W-1:0] above_key;
        logic [skvot_pkg::VAL_W-1:0] above_value;

        if (g == 0) begin : g_first
            assign below_key   = skvot_pkg::EMPTY_KEY;
            assign below_value = '0;
            assign below_lt    = 1'b1;
        end else begin : g_inner_lo
            assign below_key   = cell_key[g-1];
            assign below_value = cell_value[g-1];
            assign below_lt    = cell_lt[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign above_key   = skvot_pkg::EMPTY_KEY;
            assign above_value = '0;
        end else begin : g_inner_hi
            assign above_key   = cell_key[g+1];
            assign above_value = cell_value[g+1];
        end

        skvot_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctl         (ctl),
            .i_below_key   (below_key),
            .i_below_value (below_value),
            .i_below_lt    (below_lt),
            .i_above_key   (above_key),
            .i_above_value (above_value),
            .o_key         (cell_key[g]),
            .o_value       (cell_value[g]),
            .o_lt          (cell_lt[g]),
            .o_eq          (cell_eq[g])
        );
    end

    // Checks
    `SKVOT_ASSERT_NXT(a_accept_compare, i_clk, i_rst_n, accept, r_busy && !accept)
    `SKVOT_ASSERT_NXT(a_apply_strobe, i_clk, i_rst_n, r_apply, o_valid)
    `SKVOT_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(CAPACITY))
    `SKVOT_ASSERT_IMP(a_value_needs_hit, i_clk, i_rst_n, o_valid && (o_read_value != '0), o_hit)
    `SKVOT_ASSERT_IMP(a_one_match, i_clk, i_rst_n, r_apply && op_ok, $onehot0(cell_eq))

endmodule

// ===== design/skvot_cell.sv =====
// ----------------------------------------------------------------------------
// skvot_cell
// One slot of the sorted row: holds a key and value, compares against the
// broadcast key and shifts from either neighbour on insert or remove.
// ----------------------------------------------------------------------------
module skvot_cell (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  skvot_pkg::t_cell_ctl        i_ctl,
    input  logic [skvot_pkg::KEY_W-1:0] i_below_key,
    input  logic [skvot_pkg::VAL_W-1:0] i_below_value,
    input  logic                        i_below_lt,
    input  logic [skvot_pkg::KEY_W-1:0] i_above_key,
    input  logic [skvot_pkg::VAL_W-1:0] i_above_value,
    output logic [skvot_pkg::KEY_W-1:0] o_key,
    output logic [skvot_pkg::VAL_W-1:0] o_value,
    output logic                        o_lt,
    output logic                        o_eq
);

    logic [skvot_pkg::KEY_W-1:0] r_key;
    logic [skvot_pkg::VAL_W-1:0] r_value;
    logic                        r_lt;
    logic                        r_eq;

    // Hold key with reset to the empty mark
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= skvot_pkg::EMPTY_KEY;
        end else if (i_ctl.insert && !r_lt) begin
            r_key <= i_below_lt ? i_ctl.key : i_below_key;
        end else if (i_ctl.remove && !r_lt) begin
            r_key <= i_above_key;
        end
    end

    // Hold value; overwrite on hit, shift on insert or remove
    always_ff @(posedge i_clk) begin
        if (i_ctl.write_hit && r_eq) begin
            r_value <= i_ctl.value;
        end else if (i_ctl.insert && !r_lt) begin
            r_value <= i_below_lt ? i_ctl.value : i_below_value;
        end else if (i_ctl.remove && !r_lt) begin
            r_value <= i_above_value;
        end
    end

    // Capture compare flags against the broadcast key
    always_ff @(posedge i_clk) begin
        if (i_ctl.capture) begin
            r_lt <= (r_key < i_ctl.key);
            r_eq <= (r_key == i_ctl.key);
        end
    end

    assign o_key   = r_key;
    assign o_value = r_value;
    assign o_lt    = r_lt;
    assign o_eq    = r_eq;

endmodule
